### hdl/ismi_pkg.sv
// shared constants and control types for the interval set block
package ismi_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int INDEX_BITS_DEF  = 16;

  localparam int BOUND_W = 16;
  localparam int COUNT_W = 5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // source of a table write
  typedef enum logic [1:0] {
    WR_NEW,       // incoming interval as is
    WR_MIN_RDHI,  // min(lo, entry lo), entry hi
    WR_TGT_HI,    // merged lo, incoming hi
    WR_TGT_RDHI   // merged lo, entry hi
  } wr_sel_t;

  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    logic    wr_en;
    logic    wr_copy;
    wr_sel_t wr_sel;
    logic    tgt_load;
    logic    out_clear;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hi_lt_lo;  // incoming hi below entry lo
    logic lo_le_hi;  // incoming lo at or below entry hi
    logic hi_le_hi;  // incoming hi at or below entry hi
  } dp_status_t;

endpackage

### hdl/ismi_req_if.sv
// request channel: mode and interval bounds
interface ismi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] range_lo;
  logic [15:0] range_hi;

  modport source (output valid, output mode, output range_lo, output range_hi, input ready);
  modport sink (input valid, input mode, input range_lo, input range_hi, output ready);
endinterface

### hdl/ismi_rsp_if.sv
// result channel: read-out intervals, count and flags
interface ismi_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_lo;
  logic [15:0] out_hi;
  logic [4:0]  entry_count;
  logic        overflow;
  logic        empty_set;
  logic        last;

  modport source (output valid, output out_lo, output out_hi, output entry_count,
                  output overflow, output empty_set, output last, input ready);
  modport sink (input valid, input out_lo, input out_hi, input entry_count,
                input overflow, input empty_set, input last, output ready);
endinterface

### hdl/ismi_datapath.sv
// interval table memory, operand registers, comparators and result register
module ismi_datapath
  import ismi_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                clk,
  input  dp_cmd_t             cmd,
  input  logic [AW-1:0]       raddr,
  input  logic [AW-1:0]       waddr,
  input  logic [15:0]         range_lo,
  input  logic [15:0]         range_hi,
  output dp_status_t          status,
  output logic [BOUND_W-1:0]  out_lo,
  output logic [BOUND_W-1:0]  out_hi
);

  logic [INDEX_BITS-1:0] mem_lo [MAX_ENTRIES];
  logic [INDEX_BITS-1:0] mem_hi [MAX_ENTRIES];
  logic [INDEX_BITS-1:0] rd_lo, rd_hi;
  logic [INDEX_BITS-1:0] lo, hi, tgt_lo;
  logic [INDEX_BITS-1:0] min_lo, wr_lo, wr_hi;

  assign min_lo = (lo < rd_lo) ? lo : rd_lo;

  always_comb begin
    if (cmd.wr_copy) begin
      wr_lo = rd_lo;
      wr_hi = rd_hi;
    end else begin
      case (cmd.wr_sel)
        WR_NEW: begin
          wr_lo = lo;
          wr_hi = hi;
        end
        WR_MIN_RDHI: begin
          wr_lo = min_lo;
          wr_hi = rd_hi;
        end
        WR_TGT_HI: begin
          wr_lo = tgt_lo;
          wr_hi = hi;
        end
        WR_TGT_RDHI: begin
          wr_lo = tgt_lo;
          wr_hi = rd_hi;
        end
        default: begin
          wr_lo = lo;
          wr_hi = hi;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_lo[waddr] <= wr_lo;
      mem_hi[waddr] <= wr_hi;
    end
    if (cmd.rd_en) begin
      rd_lo <= mem_lo[raddr];
      rd_hi <= mem_hi[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      lo <= INDEX_BITS'(range_lo);
      hi <= INDEX_BITS'(range_hi);
    end
    if (cmd.tgt_load) begin
      tgt_lo <= min_lo;
    end
    if (cmd.out_clear) begin
      out_lo <= '0;
      out_hi <= '0;
    end else if (cmd.out_load) begin
      out_lo <= BOUND_W'(rd_lo);
      out_hi <= BOUND_W'(rd_hi);
    end
  end

  assign status.hi_lt_lo = hi < rd_lo;
  assign status.lo_le_hi = lo <= rd_hi;
  assign status.hi_le_hi = hi <= rd_hi;

endmodule

### hdl/ismi_ctrl.sv
// sequencer for insert walk, merge, table shifts, read-out and clear
module ismi_ctrl
  import ismi_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    mode,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    entry_count,
  output logic          overflow,
  output logic          empty_set,
  output logic          last,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] raddr,
  output logic [AW-1:0] waddr,
  input  dp_status_t    status
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_EV, S_MRG_RD, S_MRG_EV, S_CMP_RD, S_CMP_WR,
    S_SH_RD, S_SH_WR, S_RD_RD, S_RD_LD, S_EMIT
  } state_t;

  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  state_t        state;
  logic [CW-1:0] count, p, q, d;
  logic [CW-1:0] p_inc, q_inc, q_dec;

  assign p_inc = p + 1'b1;
  assign q_inc = q + 1'b1;
  assign q_dec = q - 1'b1;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign entry_count = COUNT_W'(count);

  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_NEW;
    raddr      = '0;
    waddr      = '0;
    case (state)
      S_IDLE: begin
        cmd.in_load   = in_valid;
        cmd.out_clear = in_valid;
      end
      S_INS_RD: begin
        if (p == count) begin
          cmd.wr_en = (count != FULL);
          waddr     = p[AW-1:0];
        end else begin
          cmd.rd_en = 1'b1;
          raddr     = p[AW-1:0];
        end
      end
      S_INS_EV: begin
        waddr = p[AW-1:0];
        if (!status.hi_lt_lo && status.lo_le_hi) begin
          if (status.hi_le_hi) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_MIN_RDHI;
          end else begin
            cmd.tgt_load = 1'b1;
          end
        end
      end
      S_MRG_RD: begin
        if (q == count) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_TGT_HI;
          waddr      = p[AW-1:0];
        end else begin
          cmd.rd_en = 1'b1;
          raddr     = q[AW-1:0];
        end
      end
      S_MRG_EV: begin
        waddr = p[AW-1:0];
        if (status.hi_lt_lo) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_TGT_HI;
        end else if (status.hi_le_hi) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_TGT_RDHI;
        end
      end
      S_CMP_RD: begin
        cmd.rd_en = (q != count);
        raddr     = q[AW-1:0];
      end
      S_CMP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_copy = 1'b1;
        waddr       = d[AW-1:0];
      end
      S_SH_RD: begin
        if (q == p) begin
          cmd.wr_en = 1'b1;
          waddr     = p[AW-1:0];
        end else begin
          cmd.rd_en = 1'b1;
          raddr     = q_dec[AW-1:0];
        end
      end
      S_SH_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_copy = 1'b1;
        waddr       = q[AW-1:0];
      end
      S_RD_RD: begin
        cmd.rd_en = 1'b1;
        raddr     = q[AW-1:0];
      end
      S_RD_LD: begin
        cmd.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      p         <= '0;
      q         <= '0;
      d         <= '0;
      overflow  <= 1'b0;
      empty_set <= 1'b0;
      last      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            overflow  <= 1'b0;
            empty_set <= 1'b0;
            last      <= 1'b1;
            p         <= '0;
            q         <= '0;
            case (mode)
              MODE_INSERT: state <= S_INS_RD;
              MODE_READ: begin
                if (count == '0) begin
                  empty_set <= 1'b1;
                  state     <= S_EMIT;
                end else begin
                  state <= S_RD_RD;
                end
              end
              MODE_CLEAR: begin
                count <= '0;
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INS_RD: begin
          if (p == count) begin
            if (count == FULL) begin
              overflow <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            state <= S_EMIT;
          end else begin
            state <= S_INS_EV;
          end
        end
        S_INS_EV: begin
          if (status.hi_lt_lo) begin
            if (count == FULL) begin
              overflow <= 1'b1;
              state    <= S_EMIT;
            end else begin
              q     <= count;
              state <= S_SH_RD;
            end
          end else if (status.lo_le_hi) begin
            if (status.hi_le_hi) begin
              state <= S_EMIT;
            end else begin
              q     <= p_inc;
              state <= S_MRG_RD;
            end
          end else begin
            p     <= p_inc;
            state <= S_INS_RD;
          end
        end
        S_MRG_RD: begin
          if (q == count) begin
            d     <= p_inc;
            state <= S_CMP_RD;
          end else begin
            state <= S_MRG_EV;
          end
        end
        S_MRG_EV: begin
          if (status.hi_lt_lo) begin
            d     <= p_inc;
            state <= S_CMP_RD;
          end else if (status.hi_le_hi) begin
            d     <= p_inc;
            q     <= q_inc;
            state <= S_CMP_RD;
          end else begin
            q     <= q_inc;
            state <= S_MRG_RD;
          end
        end
        S_CMP_RD: begin
          if (q == count) begin
            count <= d;
            state <= S_EMIT;
          end else begin
            state <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          q     <= q_inc;
          d     <= d + 1'b1;
          state <= S_CMP_RD;
        end
        S_SH_RD: begin
          if (q == p) begin
            count <= count + 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          q     <= q_dec;
          state <= S_SH_RD;
        end
        S_RD_RD: state <= S_RD_LD;
        S_RD_LD: begin
          last  <= (q_inc == count);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              q     <= q_inc;
              state <= S_RD_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/interval_set_merge_insert_core.sv
// top level of the sorted interval set with merge on insert
//  channel | dir | transfer moves
//  req     | in  | mode, range_lo, range_hi
//  rsp     | out | out_lo, out_hi, entry_count, overflow, empty_set, last
// one item at a time; req is ready only when the sequencer is idle
// insert: walks the table entry by entry, then shifts or compacts entries,
//   all through the single table write port and registered read port
// read: emits stored intervals one at a time, each held until taken; clear: empties the set
// rst is synchronous and empties the set; table contents are not cleared
module interval_set_merge_insert_core
  import ismi_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ismi_req_if.sink  req,
  ismi_rsp_if.source rsp
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [AW-1:0] raddr, waddr;

  ismi_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .mode        (req.mode),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .entry_count (rsp.entry_count),
    .overflow    (rsp.overflow),
    .empty_set   (rsp.empty_set),
    .last        (rsp.last),
    .cmd         (cmd),
    .raddr       (raddr),
    .waddr       (waddr),
    .status      (status)
  );

  ismi_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .raddr    (raddr),
    .waddr    (waddr),
    .range_lo (req.range_lo),
    .range_hi (req.range_hi),
    .status   (status),
    .out_lo   (rsp.out_lo),
    .out_hi   (rsp.out_hi)
  );

endmodule

### test/tb_interval_set_merge_insert_core.sv
// testbench for the interval set merge insert core: random and directed requests, scoreboard
`timescale 1ns / 1ps

module tb_interval_set_merge_insert_core;
  import ismi_pkg::*;

  localparam int NUM_ENTRIES = MAX_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [4:0]  count;
    logic        overflow;
    logic        empty_set;
    logic        last;
  } set_result_t;

  // shadow copy of the interval table and the results it predicts
  class interval_scoreboard;
    logic [15:0] shadow_lo[NUM_ENTRIES];
    logic [15:0] shadow_hi[NUM_ENTRIES];
    int unsigned shadow_count;
    set_result_t pending_results[$];
    int unsigned mismatches;

    function new();
      shadow_count = 0;
      mismatches = 0;
    endfunction

    function void queue_result(set_result_t r);
      pending_results = {pending_results, r};
    endfunction

    function void drop_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
        shadow_lo[k] = shadow_lo[k + 1];
        shadow_hi[k] = shadow_hi[k + 1];
      end
      shadow_count--;
    endfunction

    function logic add_entry(int unsigned pos, logic [15:0] lo, logic [15:0] hi);
      if (shadow_count >= NUM_ENTRIES) return 1'b1;
      for (int unsigned k = shadow_count; k > pos; k--) begin
        shadow_lo[k] = shadow_lo[k - 1];
        shadow_hi[k] = shadow_hi[k - 1];
      end
      shadow_lo[pos] = lo;
      shadow_hi[pos] = hi;
      shadow_count++;
      return 1'b0;
    endfunction

    function logic merge_interval(logic [15:0] lo, logic [15:0] hi);
      for (int unsigned p = 0; p < shadow_count; p++) begin
        if (hi < shadow_lo[p]) return add_entry(p, lo, hi);
        if (lo <= shadow_hi[p]) begin
          if (lo < shadow_lo[p]) shadow_lo[p] = lo;
          if (hi <= shadow_hi[p]) return 1'b0;
          // absorb following entries that overlap or touch
          forever begin
            if (p + 1 >= shadow_count || hi < shadow_lo[p + 1]) begin
              shadow_hi[p] = hi;
              return 1'b0;
            end
            if (hi <= shadow_hi[p + 1]) begin
              shadow_hi[p] = shadow_hi[p + 1];
              drop_entry(p + 1);
              return 1'b0;
            end
            drop_entry(p + 1);
          end
        end
      end
      return add_entry(shadow_count, lo, hi);
    endfunction

    function void note_request(logic [1:0] mode, logic [15:0] lo, logic [15:0] hi);
      set_result_t r;
      logic ovf;
      r = '0;
      r.last = 1'b1;
      case (mode)
        MODE_INSERT: begin
          ovf = merge_interval(lo, hi);
          r.count = shadow_count[4:0];
          r.overflow = ovf;
          queue_result(r);
        end
        MODE_READ: begin
          if (shadow_count == 0) begin
            r.empty_set = 1'b1;
            queue_result(r);
          end else begin
            for (int unsigned k = 0; k < shadow_count; k++) begin
              r.lo = shadow_lo[k];
              r.hi = shadow_hi[k];
              r.count = shadow_count[4:0];
              r.last = (k + 1 == shadow_count);
              queue_result(r);
            end
          end
        end
        MODE_CLEAR: begin
          shadow_count = 0;
          queue_result(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(set_result_t got);
      set_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  ismi_req_if req ();
  ismi_rsp_if rsp ();
  interval_scoreboard sb;
  int unsigned idle_cycles = 0;
  bit rsp_hold = 1'b0;

  always #5 clk = ~clk;

  interval_set_merge_insert_core DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_INSERT;
    req.range_lo = '0;
    req.range_hi = '0;
    rsp.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) sb.note_request(req.mode, req.range_lo, req.range_hi);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.out_lo, rsp.out_hi, rsp.entry_count, rsp.overflow,
                       rsp.empty_set, rsp.last});
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_hold) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        rsp_hold = 1'b0;
      end
      n = gap_len();
      if (n == 0 || $urandom_range(0, 3) != 0) rsp.ready <= 1'b1;
      else begin
        rsp.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic [1:0] mode, logic [15:0] lo, logic [15:0] hi,
                              bit no_gap = 0);
    int unsigned n;
    n = no_gap ? 0 : gap_len();
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.range_lo <= lo;
    req.range_hi <= hi;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned sel;
    logic [15:0] lo;
    logic [15:0] hi;
    sel = $urandom_range(0, 99);
    lo = 16'($urandom_range(0, 400));
    hi = lo + 16'($urandom_range(0, 40));
    if (sel < 5) send_request(MODE_CLEAR, 16'($urandom), 16'($urandom));
    else if (sel < 17) send_request(MODE_READ, 16'($urandom), 16'($urandom));
    else if (sel < 19) send_request(MODE_IGNORED, 16'($urandom), 16'($urandom));
    else if (sel < 25) send_request(MODE_INSERT, 16'($urandom), 16'($urandom));
    else send_request(MODE_INSERT, lo, hi);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty read, extremes, touching, reversed, ignored mode
    send_request(MODE_READ, 16'd0, 16'd0);
    send_request(MODE_INSERT, 16'd0, 16'd0);
    send_request(MODE_INSERT, 16'hffff, 16'hffff);
    send_request(MODE_INSERT, 16'd10, 16'd20);
    send_request(MODE_INSERT, 16'd20, 16'd25);
    send_request(MODE_INSERT, 16'd5, 16'd10);
    send_request(MODE_INSERT, 16'd40, 16'd50);
    send_request(MODE_INSERT, 16'd60, 16'd70);
    send_request(MODE_INSERT, 16'd30, 16'd65);
    send_request(MODE_INSERT, 16'd3, 16'd80);
    send_request(MODE_INSERT, 16'd200, 16'd150);
    send_request(MODE_IGNORED, 16'hffff, 16'hffff);
    send_request(MODE_READ, 16'hffff, 16'h0);
    send_request(MODE_CLEAR, 16'h0, 16'hffff);
    // fill past capacity
    for (int i = 0; i < NUM_ENTRIES + 2; i++)
      send_request(MODE_INSERT, 16'(i * 10), 16'(i * 10 + 5));
    send_request(MODE_READ, 16'h0, 16'h0);
    wait_drained();
    // long receiver hold-off while requests keep coming
    rsp_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_request(MODE_READ, 16'h0, 16'h0, 1);
    for (int i = 0; i < 140; i++) begin
      random_request();
      if (i == 70) wait_drained();
    end
    wait_drained();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
